@@ rtl/core/wls_pkg.sv @@
// Package for the windowed latency statistics block.
// Holds default parameters, controller command and status types. No dependencies.
`default_nettype none
package wls_pkg;
    localparam int WINDOW_DEF      = 10;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int STAMP_BITS      = 32;
    localparam int OUT_BITS        = 16;
    localparam int COUNT_BITS      = 7;

    typedef struct packed {
        logic store_stamp;
        logic start_reply;
        logic sum_clear;
        logic sum_step;
        logic div_start;
        logic div_sq;
        logic div_step;
        logic sq_clear;
        logic sq_step;
        logic root_start;
        logic root_step;
        logic load_out;
    } wls_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic div_last;
        logic root_last;
    } wls_stat_t;
endpackage
`default_nettype wire

@@ rtl/core/wls_datapath.sv @@
// Datapath for the windowed latency statistics: sample window, serial sum,
// shift-subtract divider, square accumulator and bitwise integer root. Uses wls_pkg.
`default_nettype none
module wls_datapath
    import wls_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire wls_cmd_t                cmd,
    output wls_stat_t                    stat,
    input  wire logic [STAMP_BITS-1:0]   now_ms,
    output logic [OUT_BITS-1:0]          latency,
    output logic [OUT_BITS-1:0]          average,
    output logic [OUT_BITS-1:0]          maximum,
    output logic [OUT_BITS-1:0]          deviation,
    output logic [COUNT_BITS-1:0]        sample_count
);
    localparam int IW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW  = $clog2(WINDOW + 1);
    localparam int SW  = SAMPLE_BITS + CW;          // sum width
    localparam int QW  = 2 * SAMPLE_BITS + CW;      // square sum width
    localparam int DW  = QW;                        // divider width
    localparam int DCW = $clog2(DW + 1);
    localparam int RH  = (QW + 1) / 2;              // root bits
    localparam int RW  = 2 * RH;
    localparam int RCW = $clog2(RH + 1);
    localparam logic [SAMPLE_BITS-1:0] SAT = {SAMPLE_BITS{1'b1}};

    logic [SAMPLE_BITS-1:0] win_mem [WINDOW];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [STAMP_BITS-1:0]  stamp_reg;
    logic [SAMPLE_BITS-1:0] lat_reg, max_reg;
    logic [IW-1:0]          slot_reg, idx_reg;
    logic [CW-1:0]          held_reg, scan_reg;
    logic                   rd_valid_reg;
    logic [SW-1:0]          sum_reg;
    logic [QW-1:0]          sq_reg;
    logic [DW-1:0]          quo_reg, rem_reg, dvd_reg;
    logic [DCW-1:0]         dcnt_reg;
    logic [SAMPLE_BITS-1:0] mean_reg;
    logic [RW-1:0]          rad_reg, rrem_reg;
    logic [RH-1:0]          root_reg;
    logic [RCW-1:0]         rcnt_reg;

    logic [STAMP_BITS-1:0]  diff;
    logic [SAMPLE_BITS-1:0] lat_sat;
    logic [SAMPLE_BITS-1:0] adiff;
    logic [2*SAMPLE_BITS-1:0] sqr;
    logic [DW:0]            rem_sh, rem_sub;
    logic [RW+1:0]          rrem_sh, trial, rrem_sub;

    assign diff    = now_ms - stamp_reg;
    assign lat_sat = (diff > STAMP_BITS'(SAT)) ? SAT : diff[SAMPLE_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.start_reply)
            win_mem[slot_reg] <= lat_sat;
        rd_data_reg <= win_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg <= '0;
            max_reg   <= '0;
            slot_reg  <= '0;
            held_reg  <= '0;
        end
        else
        begin
            if (cmd.store_stamp)
                stamp_reg <= now_ms;
            if (cmd.start_reply)
            begin
                if (lat_sat > max_reg)
                    max_reg <= lat_sat;
                slot_reg <= (32'(slot_reg) + 1 >= WINDOW) ? '0 : slot_reg + 1'b1;
                if (32'(held_reg) < WINDOW)
                    held_reg <= held_reg + 1'b1;
            end
        end
    end

    // Scan index walks the held samples; read data follows the index in the next cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.start_reply)
            lat_reg <= lat_sat;
        if (cmd.sum_clear || cmd.sq_clear)
        begin
            idx_reg      <= '0;
            scan_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else if (cmd.sum_step || cmd.sq_step)
        begin
            if (32'(idx_reg) + 1 < WINDOW)
                idx_reg <= idx_reg + 1'b1;
            scan_reg     <= scan_reg + 1'b1;
            rd_valid_reg <= 1'b1;
        end
        if (cmd.sum_clear)
            sum_reg <= '0;
        else if (cmd.sum_step && rd_valid_reg)
            sum_reg <= sum_reg + SW'(rd_data_reg);
        if (cmd.sq_clear)
            sq_reg <= '0;
        else if (cmd.sq_step && rd_valid_reg)
            sq_reg <= sq_reg + QW'(sqr);
    end

    assign adiff = (rd_data_reg >= mean_reg) ? rd_data_reg - mean_reg
                                             : mean_reg - rd_data_reg;
    assign sqr   = adiff * adiff;

    // The last held sample is on the read data when the step count reaches the count held.
    assign stat.scan_last = rd_valid_reg && (scan_reg == held_reg);

    // Restoring divider, one quotient bit per cycle; shared by mean and variance.
    assign rem_sh  = {rem_reg, dvd_reg[DW-1]};
    assign rem_sub = rem_sh - (DW+1)'(held_reg);
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dvd_reg  <= cmd.div_sq ? DW'(sq_reg) : DW'(sum_reg);
            rem_reg  <= '0;
            quo_reg  <= '0;
            dcnt_reg <= DCW'(DW);
        end
        else if (cmd.div_step)
        begin
            dvd_reg  <= dvd_reg << 1;
            dcnt_reg <= dcnt_reg - 1'b1;
            if (!rem_sub[DW])
            begin
                rem_reg <= rem_sub[DW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
        if (cmd.sq_clear)
            mean_reg <= quo_reg[SAMPLE_BITS-1:0];
    end
    assign stat.div_last = (dcnt_reg == DCW'(1));

    // Digit-by-digit root, two radicand bits per cycle.
    assign rrem_sh  = {rrem_reg, rad_reg[RW-1 -: 2]};
    assign trial    = (RW+2)'({root_reg, 2'b01});
    assign rrem_sub = rrem_sh - trial;
    always_ff @(posedge clk)
    begin
        if (cmd.root_start)
        begin
            rad_reg  <= RW'(quo_reg);
            rrem_reg <= '0;
            root_reg <= '0;
            rcnt_reg <= RCW'(RH);
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= rad_reg << 2;
            rcnt_reg <= rcnt_reg - 1'b1;
            if (!rrem_sub[RW+1])
            begin
                rrem_reg <= rrem_sub[RW-1:0];
                root_reg <= {root_reg[RH-2:0], 1'b1};
            end
            else
            begin
                rrem_reg <= rrem_sh[RW-1:0];
                root_reg <= {root_reg[RH-2:0], 1'b0};
            end
        end
    end
    assign stat.root_last = (rcnt_reg == RCW'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            latency      <= OUT_BITS'(lat_reg);
            average      <= OUT_BITS'(mean_reg);
            maximum      <= OUT_BITS'(max_reg);
            deviation    <= OUT_BITS'(root_reg);
            sample_count <= COUNT_BITS'(held_reg);
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/wls_control.sv @@
// Controller state machine for the windowed latency statistics.
// Sequences sum, divide, square sum, divide, root and the output load. Uses wls_pkg.
`default_nettype none
module wls_control
    import wls_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire logic      action,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire wls_stat_t stat,
    output wls_cmd_t       cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SUMC  = 4'd1;
    localparam logic [3:0] S_SUM   = 4'd2;
    localparam logic [3:0] S_DIV1S = 4'd3;
    localparam logic [3:0] S_DIV1  = 4'd4;
    localparam logic [3:0] S_SQC   = 4'd5;
    localparam logic [3:0] S_SQ    = 4'd6;
    localparam logic [3:0] S_DIV2S = 4'd7;
    localparam logic [3:0] S_DIV2  = 4'd8;
    localparam logic [3:0] S_ROOTS = 4'd9;
    localparam logic [3:0] S_ROOT  = 4'd10;
    localparam logic [3:0] S_LOAD  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.store_stamp = accept && !action;
                cmd.start_reply = accept && action;
                if (accept && action)
                    state_next = S_SUMC;
            end
            S_SUMC:  begin cmd.sum_clear = 1'b1; state_next = S_SUM; end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (stat.scan_last)
                    state_next = S_DIV1S;
            end
            S_DIV1S: begin cmd.div_start = 1'b1; state_next = S_DIV1; end
            S_DIV1:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_SQC;
            end
            S_SQC:   begin cmd.sq_clear = 1'b1; state_next = S_SQ; end
            S_SQ:
            begin
                cmd.sq_step = 1'b1;
                if (stat.scan_last)
                    state_next = S_DIV2S;
            end
            S_DIV2S: begin cmd.div_start = 1'b1; cmd.div_sq = 1'b1; state_next = S_DIV2; end
            S_DIV2:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_ROOTS;
            end
            S_ROOTS: begin cmd.root_start = 1'b1; state_next = S_ROOT; end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (stat.root_last)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // Wait until the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/windowed_latency_statistics.sv @@
// Windowed latency statistics, top level. Uses wls_pkg, wls_control, wls_datapath.
// A send item is accepted while the block is idle and gives no result. A reply item is
// worked through a serial sum and a square sum over the held samples, two one-bit-a-cycle
// divisions of width 2*SAMPLE_BITS plus the count width, and a two-bit-a-cycle root. The
// input stalls until the reply result is loaded to the output, so no new item is taken meanwhile.
// Reset clears stamp, maximum, slot, count and control; window entries need no reset.
`default_nettype none
module windowed_latency_statistics
    import wls_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   action,
    input  wire logic [STAMP_BITS-1:0]  now_ms,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [OUT_BITS-1:0]         latency,
    output logic [OUT_BITS-1:0]         average,
    output logic [OUT_BITS-1:0]         maximum,
    output logic [OUT_BITS-1:0]         deviation,
    output logic [COUNT_BITS-1:0]       sample_count
);
    wls_cmd_t  cmd;
    wls_stat_t stat;

    wls_control u_control (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .out_valid(out_valid), .out_stall(out_stall),
        .stat(stat), .cmd(cmd)
    );

    wls_datapath #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_datapath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .now_ms(now_ms),
        .latency(latency), .average(average), .maximum(maximum),
        .deviation(deviation), .sample_count(sample_count)
    );

`ifndef SYNTH
    a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_reply |=> in_stall)
        else $error("block accepted an item during a reply computation");
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_count != '0)
        else $error("result shown with empty window");
    a_max_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> maximum >= latency)
        else $error("maximum below newest latency");
`endif
endmodule
`default_nettype wire
